>>> rtl/core/uha_pkg.sv
// Shared types, constants and helpers of the uniform histogram accumulator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package uha_pkg;

  localparam int MAX_BINS   = 1024;
  localparam int BIN_W      = $clog2(MAX_BINS);
  localparam int COUNT_W    = 32;
  localparam int VAL_W      = 32;
  localparam int BCNT_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 112;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT  = 2'd3;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [VAL_W-1:0]    RST_RANGE_LOW  = 32'd0;
  localparam logic [VAL_W-1:0]    RST_RANGE_HIGH = 32'd65536;
  localparam logic [VAL_W-1:0]    RST_BIN_SCALE  = 32'd67043328;
  localparam logic [BCNT_W-1:0]   RST_BIN_COUNT  = 11'd1024;
  localparam logic [2*VAL_W-1:0]  HALF_Q32       = 64'h0000_0000_8000_0000;
  localparam logic [COUNT_W-1:0]  COUNT_MAX      = '1;

  typedef struct packed {
    logic cap;
    logic cmp;
    logic mul;
    logic idx;
    logic wb;
    logic clr;
  } uha_cmd_t;

  typedef struct packed {
    logic clr_last;
  } uha_sts_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

>>> rtl/core/uha_ctrl.sv
// Sequencer of the histogram accumulator: clearing pass, item steps, output valid.
// Depends on uha_pkg; drives uha_dpath through uha_cmd_t.
`timescale 1ns / 1ps

module uha_ctrl import uha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  uha_sts_t sts,
  output uha_cmd_t cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_IDX  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_WB   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_IDX;
      end
      S_IDX: begin
        cmd.idx   = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        if (!out_valid_r || out_tready) begin
          cmd.wb    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.wb) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_valid_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_WB)
    else $error("output valid rose outside write-back");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && !$past(cmd.wb))
    else $error("pending result overwritten");

endmodule

>>> rtl/core/uha_dpath.sv
// Datapath of the histogram accumulator: config registers, bin arithmetic,
// bin memory, saturating counters and output register. Depends on uha_pkg.
`timescale 1ns / 1ps

module uha_dpath import uha_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  uha_cmd_t               cmd,
  output uha_sts_t               sts,
  input  logic                   in_kind,
  input  logic [VAL_W-1:0]       in_sample,
  input  logic [BIN_W-1:0]       in_bin_select,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [VAL_W-1:0]       cfg_data,
  output logic [BIN_W-1:0]       out_bin_index,
  output logic [COUNT_W-1:0]     out_bin_value,
  output logic                   out_was_lost,
  output logic [COUNT_W-1:0]     out_in_range_total,
  output logic [COUNT_W-1:0]     out_lost_total
);

  logic signed [VAL_W-1:0] range_low_r, range_high_r;
  logic [VAL_W-1:0]        bin_scale_r;
  logic [BCNT_W-1:0]       bin_count_r;

  logic                    kind_r;
  logic signed [VAL_W-1:0] sample_r;
  logic [BIN_W-1:0]        sel_r;
  logic                    lost_r;
  logic [VAL_W-1:0]        d_r;
  logic [2*VAL_W-1:0]      prod_r;
  logic [BIN_W-1:0]        idx_r;
  logic [COUNT_W-1:0]      rd_data_r;
  logic [BIN_W-1:0]        clr_addr_r;
  logic [COUNT_W-1:0]      in_range_r, in_range_nxt;
  logic [COUNT_W-1:0]      lost_cnt_r, lost_cnt_nxt;

  logic [BIN_W-1:0]        bin_index_r;
  logic [COUNT_W-1:0]      bin_value_r;
  logic                    was_lost_r;
  logic [COUNT_W-1:0]      in_range_total_r;
  logic [COUNT_W-1:0]      lost_total_r;

  logic [COUNT_W-1:0]      mem [MAX_BINS];

  logic [VAL_W:0]          diff;
  logic [2*VAL_W-1:0]      rnd_sum;
  logic [VAL_W-1:0]        hit;
  logic [BCNT_W-1:0]       n_use;
  logic [BIN_W-1:0]        last;
  logic                    add_hit, add_lost;
  logic [COUNT_W-1:0]      new_bin;
  logic                    mem_we;
  logic [BIN_W-1:0]        mem_waddr;
  logic [COUNT_W-1:0]      mem_wdata;

  assign diff    = {sample_r[VAL_W-1], sample_r} - {range_low_r[VAL_W-1], range_low_r};
  assign rnd_sum = prod_r + HALF_Q32;
  assign hit     = rnd_sum[2*VAL_W-1:VAL_W];

  always_comb begin
    n_use = bin_count_r;
    if (bin_count_r == '0) begin
      n_use = BCNT_W'(1);
    end else if (bin_count_r > BCNT_W'(MAX_BINS)) begin
      n_use = BCNT_W'(MAX_BINS);
    end
  end
  assign last = BIN_W'(n_use - 1'b1);

  assign add_hit   = (kind_r == KIND_ADD) && !lost_r;
  assign add_lost  = (kind_r == KIND_ADD) && lost_r;
  assign new_bin   = sat_inc(rd_data_r);
  assign mem_we    = cmd.clr || (cmd.wb && add_hit);
  assign mem_waddr = cmd.clr ? clr_addr_r : idx_r;
  assign mem_wdata = cmd.clr ? '0 : new_bin;

  assign in_range_nxt = add_hit  ? sat_inc(in_range_r) : in_range_r;
  assign lost_cnt_nxt = add_lost ? sat_inc(lost_cnt_r) : lost_cnt_r;

  assign sts.clr_last = (clr_addr_r == BIN_W'(MAX_BINS - 1));

  assign out_bin_index      = bin_index_r;
  assign out_bin_value      = bin_value_r;
  assign out_was_lost       = was_lost_r;
  assign out_in_range_total = in_range_total_r;
  assign out_lost_total     = lost_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= RST_RANGE_LOW;
      range_high_r <= RST_RANGE_HIGH;
      bin_scale_r  <= RST_BIN_SCALE;
      bin_count_r  <= RST_BIN_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_LOW:  range_low_r  <= cfg_data;
        REG_RANGE_HIGH: range_high_r <= cfg_data;
        REG_BIN_SCALE:  bin_scale_r  <= cfg_data;
        REG_BIN_COUNT:  bin_count_r  <= cfg_data[BCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      in_range_r <= '0;
      lost_cnt_r <= '0;
    end else begin
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.wb) begin
        in_range_r <= in_range_nxt;
        lost_cnt_r <= lost_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      kind_r   <= in_kind;
      sample_r <= in_sample;
      sel_r    <= in_bin_select;
    end
    if (cmd.cmp) begin
      lost_r <= (sample_r < range_low_r) || (sample_r > range_high_r);
      d_r    <= diff[VAL_W-1:0];
    end
    if (cmd.mul) begin
      prod_r <= (2*VAL_W)'(d_r) * (2*VAL_W)'(bin_scale_r);
    end
    if (cmd.idx) begin
      if (kind_r == KIND_READ) begin
        idx_r <= sel_r;
      end else if (hit > VAL_W'(last)) begin
        idx_r <= last;
      end else begin
        idx_r <= hit[BIN_W-1:0];
      end
    end
    if (cmd.wb) begin
      bin_index_r      <= add_lost ? '0 : idx_r;
      bin_value_r      <= (kind_r == KIND_READ) ? rd_data_r : (lost_r ? '0 : new_bin);
      was_lost_r       <= add_lost;
      in_range_total_r <= in_range_nxt;
      lost_total_r     <= lost_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[idx_r];
  end

  a_idx_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.idx) && (kind_r == KIND_ADD) |-> idx_r <= last)
    else $error("bin index beyond last bin in use");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb && add_hit |-> new_bin != '0)
    else $error("bin count written back as zero");

  a_totals_monotone: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> in_range_r >= $past(in_range_r)
                              && lost_cnt_r >= $past(lost_cnt_r))
    else $error("total counter decreased");

endmodule

>>> rtl/core/uniform_histogram_accumulator_unit.sv
// Uniform histogram accumulator, top level.
// Channel in carries one sample (add) or one bin read as a transaction.
// Samples in [range_low, range_high] are counted into bins by
// round((sample - range_low) * bin_scale), limited to the last bin in use;
// samples outside the range raise the lost total. Every transaction returns
// one result transaction with the bin, its count and both running totals.
// Configuration writes go through the cfg channel (index 0 range_low,
// 1 range_high, 2 bin_scale, 3 bin_count) and are taken in every cycle;
// write them only while no transaction is in flight.
// After reset the bin memory is cleared one entry a cycle, all 1024 entries,
// before in_tready first rises. Counters and registers take reset values.
// The controller steps compare, 32x32 multiply, index, memory read and
// write-back in turn, one transaction at a time; a new transaction is
// accepted only after the last one has passed write-back.
// If out_tready is low the result is held in the output register; the next
// transaction is still accepted and waits at write-back until the result
// is taken. Depends on uha_pkg, uha_ctrl, uha_dpath.
`timescale 1ns / 1ps

module uniform_histogram_accumulator_unit import uha_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample[31:0], bin_select[41:32], zero pad
  input  logic                  in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // bin_index[9:0], bin_value[41:10],
                                            // in_range_total[73:42], lost_total[105:74], pad
  output logic                  out_tuser,  // was_lost
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [VAL_W-1:0]      cfg_data
);

  uha_cmd_t           cmd;
  uha_sts_t           sts;
  logic [BIN_W-1:0]   bin_index;
  logic [COUNT_W-1:0] bin_value;
  logic [COUNT_W-1:0] in_range_total;
  logic [COUNT_W-1:0] lost_total;

  assign cfg_ready = 1'b1;

  uha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  uha_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_tuser),
    .in_sample          (in_tdata[VAL_W-1:0]),
    .in_bin_select      (in_tdata[VAL_W+BIN_W-1:VAL_W]),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_bin_index      (bin_index),
    .out_bin_value      (bin_value),
    .out_was_lost       (out_tuser),
    .out_in_range_total (in_range_total),
    .out_lost_total     (lost_total)
  );

  assign out_tdata = {{(OUT_DATA_W - BIN_W - 3*COUNT_W){1'b0}},
                      lost_total, in_range_total, bin_value, bin_index};

endmodule

>>> verif/uniform_histogram_accumulator_unit_tb.sv
// Self-checking bench for uniform_histogram_accumulator_unit: streams adds and bin reads
// under several range/scale/bin-count settings and checks every result against a local
// bin-count model. Depends on uha_pkg and the RTL top level only.
`timescale 1ns / 1ps

module uniform_histogram_accumulator_unit_tb;
  import uha_pkg::*;

  localparam int     CYCLE_LIMIT   = 400000;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     DRAIN_CYCLES  = 12;
  localparam int     RUN_ITEMS     = 170;
  localparam longint MIN_Q         = -64'sd2147483648;
  localparam longint MAX_Q         = 64'sd2147483647;
  localparam logic [63:0] ROUND_HALF = 64'h0000_0000_8000_0000;

  typedef enum logic [1:0] {OP_ITEM, OP_WRITE, OP_SYNC} feed_op_t;

  typedef struct {
    feed_op_t                op;
    logic                    kind;
    logic [31:0]             sample;
    logic [BIN_W-1:0]        sel;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [VAL_W-1:0]        reg_data;
    int                      hold;
    bit                      calm;
  } feed_t;

  typedef struct packed {
    logic [BIN_W-1:0]   bin_index;
    logic [31:0]        bin_value;
    logic               was_lost;
    logic [31:0]        in_range_total;
    logic [31:0]        lost_total;
  } tally_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = KIND_ADD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_RANGE_LOW;
  logic [VAL_W-1:0]      cfg_data   = '0;

  // model state
  logic [31:0]      bin_tally [MAX_BINS];
  logic [31:0]      pred_in_range = '0;
  logic [31:0]      pred_lost     = '0;
  logic [VAL_W-1:0] win_low       = RST_RANGE_LOW;
  logic [VAL_W-1:0] win_high      = RST_RANGE_HIGH;
  logic [VAL_W-1:0] step_scale    = RST_BIN_SCALE;
  logic [BCNT_W-1:0] bins_cfg     = RST_BIN_COUNT;

  feed_t  sample_feed[$];
  tally_t due_tallies[$];

  int  sent = 0, rcvd = 0, errors = 0, settle = 0, gap = 0, stall = 0, cycles = 0;
  int  item_seq = 0, n_hits = 0, n_lost = 0, n_reads = 0, n_writes = 0, n_settings = 0;
  bit  calm_now = 1'b0;
  bit  stall_mode = 1'b1;

  uniform_histogram_accumulator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic tally_t tally_item(input logic kind, input logic [31:0] sample,
                                        input logic [BIN_W-1:0] sel);
    tally_t      r;
    longint      x, lo, hi;
    logic [63:0] d, prod, idx, last;
    r = '0;
    if (kind == KIND_ADD) begin
      x  = longint'($signed(sample));
      lo = longint'($signed(win_low));
      hi = longint'($signed(win_high));
      if (x < lo || x > hi) begin
        pred_lost = bump(pred_lost);
        r.was_lost = 1'b1;
      end else begin
        d    = x - lo;
        prod = d * {32'd0, step_scale};
        if (bins_cfg == '0) last = 64'd0;
        else if (bins_cfg > BCNT_W'(MAX_BINS)) last = 64'(MAX_BINS - 1);
        else last = 64'(bins_cfg) - 64'd1;
        idx = (prod + ROUND_HALF) >> 32;
        if (idx > last) idx = last;
        bin_tally[idx[BIN_W-1:0]] = bump(bin_tally[idx[BIN_W-1:0]]);
        r.bin_index = idx[BIN_W-1:0];
        r.bin_value = bin_tally[idx[BIN_W-1:0]];
        pred_in_range = bump(pred_in_range);
      end
    end else begin
      r.bin_index = sel;
      r.bin_value = bin_tally[sel];
    end
    r.in_range_total = pred_in_range;
    r.lost_total     = pred_lost;
    return r;
  endfunction

  task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    case (idx)
      REG_RANGE_LOW:  win_low    = data;
      REG_RANGE_HIGH: win_high   = data;
      REG_BIN_SCALE:  step_scale = data;
      REG_BIN_COUNT:  bins_cfg   = data[BCNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endtask

  // stimulus queue fill
  task automatic queue_item(input logic kind, input logic [31:0] sample,
                            input logic [BIN_W-1:0] sel, input bit calm);
    feed_t f;
    f = '{op: OP_ITEM, kind: kind, sample: sample, sel: sel, reg_idx: REG_RANGE_LOW,
          reg_data: '0, hold: 0, calm: calm};
    if (!calm && (item_seq / 40) % 3 != 0 && $urandom_range(0, 3) == 0)
      f.hold = $urandom_range(1, 16);
    item_seq++;
    sample_feed.push_back(f);
  endtask

  task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    feed_t f;
    f = '{op: OP_WRITE, kind: KIND_ADD, sample: '0, sel: '0, reg_idx: idx, reg_data: data,
          hold: 0, calm: 1'b0};
    sample_feed.push_back(f);
  endtask

  task automatic queue_sync();
    feed_t f;
    f = '{op: OP_SYNC, kind: KIND_ADD, sample: '0, sel: '0, reg_idx: REG_RANGE_LOW,
          reg_data: '0, hold: 0, calm: 1'b0};
    sample_feed.push_back(f);
  endtask

  task automatic queue_setting(input logic [31:0] lo, input logic [31:0] hi,
                               input logic [31:0] sc, input logic [BCNT_W-1:0] cnt);
    queue_write(REG_RANGE_LOW, lo);
    queue_write(REG_RANGE_HIGH, hi);
    queue_write(REG_BIN_SCALE, sc);
    queue_write(REG_BIN_COUNT, {21'd0, cnt});
    n_settings++;
  endtask

  task automatic queue_random_run(input int fixed_cnt, input int n, input bit calm);
    longint           lo, hi, span, x, rnd, sc;
    logic [BCNT_W-1:0] cnt;
    int               eff, pick;
    if (fixed_cnt >= 0) cnt = BCNT_W'(fixed_cnt);
    else begin
      case ($urandom_range(0, 9))
        0:       cnt = BCNT_W'(2);
        1:       cnt = BCNT_W'(1024);
        2:       cnt = BCNT_W'(0);
        3:       cnt = BCNT_W'($urandom_range(1025, 2047));
        default: cnt = BCNT_W'($urandom_range(2, 1024));
      endcase
    end
    eff = (cnt == '0) ? 1 : ((cnt > BCNT_W'(MAX_BINS)) ? MAX_BINS : int'(cnt));
    case ($urandom_range(0, 2))
      0:       span = longint'($urandom_range(1, 262144));
      1:       span = longint'($urandom_range(1, 1 << 24));
      default: span = longint'($urandom) + 1;
    endcase
    if (span > 64'sd4294967295) span = 64'sd4294967295;
    lo = longint'($signed($urandom));
    if (lo + span > MAX_Q) lo = MAX_Q - span;
    hi = lo + span;
    sc = (longint'(eff - 1) <<< 32) / span;
    if (sc > 64'sd4294967295) sc = 64'sd4294967295;
    if ($urandom_range(0, 5) == 0) sc = longint'($urandom);
    queue_setting(lo[31:0], hi[31:0], sc[31:0], cnt);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) queue_sync();
      pick = $urandom_range(0, 19);
      rnd  = longint'({$urandom, $urandom} >> 1);
      if (pick < 5) begin
        queue_item(KIND_READ, $urandom,
                   ($urandom_range(0, 3) == 0) ? BIN_W'($urandom)
                                               : BIN_W'($urandom_range(0, eff - 1)), calm);
      end else begin
        if (pick < 8) begin
          if (lo > MIN_Q && (hi == MAX_Q || $urandom_range(0, 1) == 0))
            x = (pick == 5) ? lo - 1 : lo - 1 - rnd % (lo - MIN_Q);
          else if (hi < MAX_Q)
            x = (pick == 5) ? hi + 1 : hi + 1 + rnd % (MAX_Q - hi);
          else
            x = longint'($signed($urandom));
        end else if (pick < 10) begin
          x = $urandom_range(0, 1) ? lo : hi;
        end else begin
          x = lo + rnd % (span + 1);
        end
        queue_item(KIND_ADD, x[31:0], BIN_W'($urandom), calm);
      end
    end
  endtask

  // driver: input and configuration channels
  always @(posedge clk) begin
    feed_t  head;
    tally_t r;
    logic   nv, ncv;
    if (rst_n) begin
      nv  = in_tvalid;
      ncv = cfg_valid;
      if (in_tvalid && in_tready) begin
        r = tally_item(in_tuser, in_tdata[31:0], in_tdata[41:32]);
        due_tallies.push_back(r);
        sent++;
        if (in_tuser == KIND_READ) n_reads++;
        else if (r.was_lost) n_lost++;
        else n_hits++;
        nv = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_setting(cfg_index, cfg_data);
        n_writes++;
        ncv = 1'b0;
      end
      if (sent == rcvd && !nv) settle++;
      else settle = 0;
      if (!nv && !ncv && sample_feed.size() != 0) begin
        head = sample_feed[0];
        case (head.op)
          OP_ITEM: begin
            if (gap < head.hold) begin
              gap++;
            end else begin
              gap = 0;
              in_tdata <= {{(IN_DATA_W - 32 - BIN_W){1'b0}}, head.sel, head.sample};
              in_tuser <= head.kind;
              calm_now <= head.calm;
              nv = 1'b1;
              void'(sample_feed.pop_front());
            end
          end
          OP_WRITE: begin
            if (settle >= SETTLE_CYCLES) begin
              cfg_index <= head.reg_idx;
              cfg_data  <= head.reg_data;
              ncv = 1'b1;
              void'(sample_feed.pop_front());
            end
          end
          OP_SYNC: begin
            if (sent == rcvd) void'(sample_feed.pop_front());
          end
          default: ;
        endcase
      end
      in_tvalid <= nv;
      cfg_valid <= ncv;
    end
  end

  // result-side backpressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (stall != 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (!calm_now && stall_mode && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      if ($urandom_range(0, 299) == 0) stall_mode = !stall_mode;
    end
  end

  // monitor
  always @(posedge clk) begin
    tally_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_tallies.size() == 0) begin
        $error("result transaction with no prediction pending");
        errors++;
      end else begin
        want = due_tallies.pop_front();
        check_field("bin_index", {22'd0, want.bin_index}, {22'd0, out_tdata[9:0]});
        check_field("bin_value", want.bin_value, out_tdata[41:10]);
        check_field("was_lost", {31'd0, want.was_lost}, {31'd0, out_tuser});
        check_field("in_range_total", want.in_range_total, out_tdata[73:42]);
        check_field("lost_total", want.lost_total, out_tdata[105:74]);
      end
      rcvd <= rcvd + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    foreach (bin_tally[i]) bin_tally[i] = '0;

    // reset setting: [0, 1.0], 1024 bins
    queue_item(KIND_ADD, 32'd0, '0, 1'b0);
    queue_item(KIND_ADD, 32'd65536, '1, 1'b0);
    queue_item(KIND_ADD, 32'd32768, '0, 1'b0);
    queue_item(KIND_ADD, 32'd32767, '1, 1'b0);
    queue_item(KIND_ADD, 32'd65537, '0, 1'b0);
    queue_item(KIND_ADD, 32'hFFFF_FFFF, '0, 1'b0);
    queue_item(KIND_ADD, 32'h8000_0000, '1, 1'b0);
    queue_item(KIND_ADD, 32'h7FFF_FFFF, '0, 1'b0);
    queue_item(KIND_ADD, 32'd0, '1, 1'b0);
    queue_item(KIND_READ, 32'hFFFF_FFFF, 10'd0, 1'b0);
    queue_item(KIND_READ, 32'd0, 10'd1023, 1'b0);
    queue_item(KIND_READ, 32'd0, 10'd512, 1'b0);
    queue_item(KIND_READ, 32'd0, 10'd1, 1'b0);
    // full signed range
    queue_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'd1023, 11'd1024);
    queue_item(KIND_ADD, 32'h8000_0000, '0, 1'b0);
    queue_item(KIND_ADD, 32'h7FFF_FFFF, '0, 1'b0);
    queue_item(KIND_ADD, 32'd0, '0, 1'b0);
    // inverted range loses everything
    queue_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'd1023, 11'd1024);
    queue_item(KIND_ADD, 32'd0, '0, 1'b0);
    queue_item(KIND_ADD, 32'h7FFF_FFFF, '0, 1'b0);
    queue_item(KIND_ADD, 32'h8000_0000, '0, 1'b0);
    // maximum scale, bin count above store size
    queue_setting(32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 11'd2047);
    queue_item(KIND_ADD, 32'd1, '0, 1'b0);
    queue_item(KIND_ADD, 32'h7FFF_FFFF, '0, 1'b0);
    queue_item(KIND_READ, 32'd0, 10'd1023, 1'b0);
    // zero bin count and zero scale
    queue_setting(32'd0, 32'd65536, 32'd0, 11'd0);
    queue_item(KIND_ADD, 32'd5, '0, 1'b0);
    queue_item(KIND_READ, 32'd0, 10'd1023, 1'b0);

    queue_random_run(2, RUN_ITEMS, 1'b0);
    for (int k = 0; k < 6; k++) queue_random_run(-1, RUN_ITEMS, 1'b0);
    queue_random_run(-1, RUN_ITEMS, 1'b1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (sample_feed.size() != 0 || in_tvalid || cfg_valid) @(posedge clk);
    while (due_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d in-range adds, %0d lost adds, %0d bin reads", n_hits, n_lost, n_reads);
    $display("     %0d register writes across %0d settings", n_writes, n_settings);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
